// File: rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: buddy block allocator shared definitions
// Sizes, codes and index helpers for the buddy tree, free lists and heap.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int HEAP_LOG2      = 16;
   localparam int MIN_BLOCK_LOG2 = 4;
   localparam int HEADER_BYTES   = 8;
   localparam int LINK_BYTES     = 16;
   localparam int BUCKETS        = 13;

   localparam int ADDR_W    = 48;
   localparam int REQ_W     = 16;
   localparam int BKT_W     = $clog2(BUCKETS);
   localparam int SLOT_W    = BUCKETS - 1;
   localparam int SLOTS     = 1 << SLOT_W;
   localparam int LEAF_LOG2 = HEAP_LOG2 - SLOT_W;
   localparam int LINK_FW   = BUCKETS;
   localparam int LINK_W    = 2 * LINK_FW;
   localparam int NODE_W    = BUCKETS;
   localparam int OFF_W     = HEAP_LOG2;
   localparam int SIZE_W    = HEAP_LOG2 + 1;
   localparam int NEED_W    = REQ_W + 1;
   localparam int SUM_W     = ADDR_W + 2;
   localparam longint HEAP_SIZE = longint'(1) << HEAP_LOG2;

   localparam logic [LINK_FW-1:0] NIL = LINK_FW'(SLOTS);

   // configuration port
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;
   localparam int CSR_SEL = 3;
   localparam logic REG_HEAP_START = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // first node index of a bucket level
   function automatic logic [NODE_W-1:0] root_node(input logic [BKT_W-1:0] b);
      return (NODE_W'(1) << b) - NODE_W'(1);
   endfunction

   // split-mark slot of a node's parent
   function automatic logic [SLOT_W-1:0] up_slot(input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] t;
      t = node - NODE_W'(1);
      return t[SLOT_W:1];
   endfunction

   // free-list slot of node at level b
   function automatic logic [SLOT_W-1:0] node_slot(input logic [NODE_W-1:0] node,
                                                  input logic [BKT_W-1:0] b);
      logic [NODE_W-1:0] d;
      d = node - root_node(b);
      d = d << (SLOT_W - int'(b));
      return d[SLOT_W-1:0];
   endfunction

   function automatic logic [NODE_W-1:0] node_of_off(input logic [OFF_W-1:0] off,
                                                    input logic [BKT_W-1:0] b);
      logic [OFF_W-1:0] q;
      q = off >> (OFF_W - int'(b));
      return NODE_W'(q) + root_node(b);
   endfunction

   function automatic logic [SIZE_W-1:0] block_size(input logic [BKT_W-1:0] b);
      return SIZE_W'(1) << (HEAP_LOG2 - int'(b));
   endfunction

   // smallest block that holds need bytes, saturating at the top bucket
   function automatic logic [BKT_W-1:0] pick_bucket(input logic [NEED_W-1:0] need);
      logic [BKT_W-1:0] b;
      b = '0;
      for (int k = BUCKETS - 1; k >= 0; k--) begin
         if ((longint'(1) << (MIN_BLOCK_LOG2 + k)) >= longint'(need)) begin
            b = BKT_W'(BUCKETS - 1 - k);
         end
      end
      return b;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/buddy_block_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_top: binary buddy allocator
// Command-driven allocate/free over a 64 KiB buddy heap with lazy growth.
// ----------------------------------------------------------------------------
// Flow: one word at a time. A null free or an oversized allocate fails without
//   touching the tree. Free work grows with each buddy merge; allocate work grows
//   with each empty bucket tried, each split and each tree growth level.
// Throughput: busy drops in the cycle the result strobe shows, and start is
//   taken again at the edge ending that cycle. Results cannot be stalled.
// Reset: synchronous; then split marks cleared one per cycle over all 4096 slots.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [bba_pkg::REQ_W-1:0]    req_request_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]   req_block_address,
   output logic                         rsp_valid,
   output logic                         rsp_success,
   output logic [bba_pkg::ADDR_W-1:0]   rsp_granted_address,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bba_pkg::CSR_AW-1:0]   paddr,
   input  logic [bba_pkg::CSR_DW-1:0]   pwdata,
   output logic [bba_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   import bba_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR, S_IDLE,
      S_A_START, S_A_LOOP, S_A_GROWN, S_A_POPPED, S_A_REGROWN, S_A_ADD,
      S_A_MARKED, S_A_SPLIT, S_A_SPUSH,
      S_F_START, S_F_SIZE, S_F_NODE, S_F_LOOP, S_F_FLIPPED, S_F_UP, S_F_PUSH,
      S_DONE_OK, S_DONE_FAIL,
      S_G_CHK, S_G_DEC, S_G_A1, S_G_B1, S_G_B2,
      S_MARK, S_FLIP, S_FLIP2,
      S_PO0, S_PU0, S_PU1, S_PU2,
      S_TK0, S_TK1, S_TK2, S_TK3, S_TK4
   } state_type;

   // sequencer and return points
   state_type state_ff, ret_ff, gret_ff;

   // allocator state
   logic [LINK_FW-1:0] heads_ff [BUCKETS];
   logic [BKT_W-1:0]   rb_ff;
   logic [ADDR_W-1:0]  hw_ff, hs_ff, lim_ff;
   logic [SLOT_W-1:0]  cnt_ff;

   // per-item working registers
   logic [REQ_W-1:0]   req_ff;
   logic               addr_zero_ff;
   logic [BKT_W-1:0]   want_ff, cur_b_ff, target_ff, sub_b_ff;
   logic [LINK_FW-1:0] s_ff, sub_s_ff, p_ff, n_ff;
   logic [NODE_W-1:0]  node_ff, fnode_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [SUM_W-1:0]   base_ff, sum_ff;
   logic               retry_ff, grow_ok_ff, mark_ok_ff, flip_ff;

   logic               rsp_valid_ff, rsp_success_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;

   // memories
   logic               sp_we, lk_we, sz_we;
   logic [SLOT_W-1:0]  sp_waddr, sp_raddr, lk_waddr, lk_raddr, sz_waddr, sz_raddr;
   logic [0:0]         sp_wdata, sp_rdata;
   logic [LINK_W-1:0]  lk_wdata, lk_rdata;
   logic [REQ_W-1:0]   sz_wdata, sz_rdata;

   // combinational helpers
   logic               accept, cfg_wr;
   logic [NEED_W-1:0]  need_req;
   logic [SIZE_W-1:0]  bsize, need_blk;
   logic [NODE_W-1:0]  groot;
   logic [SLOT_W-1:0]  gright;
   logic [ADDR_W-1:0]  grant;
   logic [ADDR_W:0]    base_mark;
   logic [LINK_FW-1:0] tk_prev;

   assign accept    = start && (state_ff == S_IDLE);
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign need_req  = NEED_W'(req_ff) + NEED_W'(HEADER_BYTES);
   assign bsize     = block_size(cur_b_ff);
   assign need_blk  = (cur_b_ff < want_ff) ? (bsize >> 1) + SIZE_W'(LINK_BYTES) : bsize;
   assign groot     = root_node(rb_ff);
   assign gright    = node_slot(groot + NODE_W'(1), rb_ff);
   assign grant     = base_ff[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
   assign base_mark = (ADDR_W+1)'(pwdata[ADDR_W-1:0]) + (ADDR_W+1)'(LINK_BYTES);
   assign tk_prev   = lk_rdata[LINK_W-1:LINK_FW];

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign pready              = 1'b1;
   assign prdata = (paddr[CSR_SEL] == REG_HEAP_LIMIT) ? CSR_DW'(lim_ff) : CSR_DW'(hs_ff);

   bba_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_split (
      .clock(clock), .wr_en(sp_we), .wr_addr(sp_waddr), .wr_data(sp_wdata),
      .rd_addr(sp_raddr), .rd_data(sp_rdata)
   );

   bba_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_links (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
      .rd_addr(lk_raddr), .rd_data(lk_rdata)
   );

   bba_ram #(.WIDTH(REQ_W), .DEPTH(SLOTS)) u_sizes (
      .clock(clock), .wr_en(sz_we), .wr_addr(sz_waddr), .wr_data(sz_wdata),
      .rd_addr(sz_raddr), .rd_data(sz_rdata)
   );

   // RAM port steering; read data is registered and shows in the cycle after the address
   always_comb begin
      sp_we    = 1'b0;
      sp_waddr = cnt_ff;
      sp_wdata = 1'b0;
      sp_raddr = up_slot(fnode_ff);
      lk_we    = 1'b0;
      lk_waddr = sub_s_ff[SLOT_W-1:0];
      lk_wdata = {NIL, heads_ff[sub_b_ff]};
      lk_raddr = sub_s_ff[SLOT_W-1:0];
      sz_we    = 1'b0;
      sz_waddr = s_ff[SLOT_W-1:0];
      sz_wdata = req_ff;
      sz_raddr = off_ff[OFF_W-1:LEAF_LOG2];
      case (state_ff)
         S_CLEAR: begin
            sp_we = 1'b1;
            if (cnt_ff == '0) begin
               // block 0 starts alone on the top-level list
               lk_we    = 1'b1;
               lk_waddr = '0;
               lk_wdata = {NIL, NIL};
            end
         end
         S_G_CHK: sp_raddr = up_slot(groot);
         S_FLIP2: begin
            sp_we    = 1'b1;
            sp_waddr = up_slot(fnode_ff);
            sp_wdata = ~sp_rdata;
         end
         S_PU0: lk_we = 1'b1;
         S_PU1: lk_raddr = n_ff[SLOT_W-1:0];
         S_PU2: begin
            lk_we    = 1'b1;
            lk_waddr = n_ff[SLOT_W-1:0];
            lk_wdata = {LINK_FW'(sub_s_ff[SLOT_W-1:0]), lk_rdata[LINK_FW-1:0]};
         end
         S_TK1: lk_raddr = tk_prev[SLOT_W-1:0];
         S_TK2: begin
            lk_we    = 1'b1;
            lk_waddr = p_ff[SLOT_W-1:0];
            lk_wdata = {tk_prev, n_ff};
         end
         S_TK3: lk_raddr = n_ff[SLOT_W-1:0];
         S_TK4: begin
            lk_we    = 1'b1;
            lk_waddr = n_ff[SLOT_W-1:0];
            lk_wdata = {p_ff, lk_rdata[LINK_FW-1:0]};
         end
         S_A_SPLIT: sz_we = !(cur_b_ff < want_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         gret_ff      <= S_IDLE;
         cnt_ff       <= '0;
         rb_ff        <= BKT_W'(BUCKETS - 1);
         hs_ff        <= '0;
         lim_ff       <= ADDR_W'(HEAP_SIZE);
         hw_ff        <= ADDR_W'(LINK_BYTES);
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < BUCKETS; k++) begin
            heads_ff[k] <= (k == BUCKETS - 1) ? '0 : NIL;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + SLOT_W'(1);
               if (cnt_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  req_ff       <= req_request_bytes;
                  addr_zero_ff <= (req_block_address == '0);
                  off_ff       <= req_block_address[OFF_W-1:0] - OFF_W'(HEADER_BYTES)
                                  - hs_ff[OFF_W-1:0];
                  state_ff     <= (req_op == OP_FREE) ? S_F_START : S_A_START;
               end
            end

            // ---------------- allocate ----------------
            S_A_START: begin
               want_ff  <= pick_bucket(need_req);
               cur_b_ff <= pick_bucket(need_req);
               retry_ff <= 1'b0;
               state_ff <= (SUM_W'(need_req) > SUM_W'(HEAP_SIZE)) ? S_DONE_FAIL : S_A_LOOP;
            end
            S_A_LOOP: begin
               target_ff <= cur_b_ff;
               gret_ff   <= S_A_GROWN;
               state_ff  <= S_G_CHK;
            end
            S_A_GROWN, S_A_REGROWN: begin
               if (!grow_ok_ff) begin
                  state_ff <= S_DONE_FAIL;
               end else begin
                  if (state_ff == S_A_REGROWN) begin
                     retry_ff <= 1'b1;
                  end
                  sub_b_ff <= cur_b_ff;
                  ret_ff   <= S_A_POPPED;
                  state_ff <= S_PO0;
               end
            end
            S_A_POPPED: begin
               if (s_ff == NIL) begin
                  if (retry_ff) begin
                     state_ff <= S_DONE_FAIL;
                  end else if (cur_b_ff != rb_ff || cur_b_ff == '0) begin
                     if (cur_b_ff == '0) begin
                        state_ff <= S_DONE_FAIL;
                     end else begin
                        cur_b_ff <= cur_b_ff - BKT_W'(1);
                        state_ff <= S_A_LOOP;
                     end
                  end else begin
                     // root level is empty: grow one level further and retry
                     target_ff <= cur_b_ff - BKT_W'(1);
                     gret_ff   <= S_A_REGROWN;
                     state_ff  <= S_G_CHK;
                  end
               end else begin
                  off_ff   <= {s_ff[SLOT_W-1:0], {LEAF_LOG2{1'b0}}};
                  base_ff  <= SUM_W'(hs_ff) + SUM_W'({s_ff[SLOT_W-1:0], {LEAF_LOG2{1'b0}}});
                  state_ff <= S_A_ADD;
               end
            end
            S_A_ADD: begin
               sum_ff   <= base_ff + SUM_W'(need_blk);
               ret_ff   <= S_A_MARKED;
               state_ff <= S_MARK;
            end
            S_A_MARKED: begin
               if (!mark_ok_ff) begin
                  // limit hit: put the popped block back
                  sub_b_ff <= cur_b_ff;
                  sub_s_ff <= s_ff;
                  ret_ff   <= S_DONE_FAIL;
                  state_ff <= S_PU0;
               end else begin
                  node_ff  <= node_of_off(off_ff, cur_b_ff);
                  fnode_ff <= node_of_off(off_ff, cur_b_ff);
                  ret_ff   <= S_A_SPLIT;
                  state_ff <= (node_of_off(off_ff, cur_b_ff) != '0) ? S_FLIP : S_A_SPLIT;
               end
            end
            S_A_SPLIT: begin
               if (cur_b_ff < want_ff) begin
                  node_ff  <= {node_ff[NODE_W-2:0], 1'b1};
                  fnode_ff <= {node_ff[NODE_W-2:0], 1'b1};
                  cur_b_ff <= cur_b_ff + BKT_W'(1);
                  ret_ff   <= S_A_SPUSH;
                  state_ff <= S_FLIP;
               end else begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_success_ff <= (grant != '0);
                  rsp_addr_ff    <= grant;
                  state_ff       <= S_IDLE;
               end
            end
            S_A_SPUSH: begin
               // right half goes on the list of the smaller bucket
               sub_b_ff <= cur_b_ff;
               sub_s_ff <= LINK_FW'(node_slot(node_ff + NODE_W'(1), cur_b_ff));
               ret_ff   <= S_A_SPLIT;
               state_ff <= S_PU0;
            end

            // ---------------- free ----------------
            S_F_START: begin
               state_ff <= addr_zero_ff ? S_DONE_FAIL : S_F_SIZE;
            end
            S_F_SIZE: begin
               cur_b_ff <= pick_bucket(NEED_W'(sz_rdata) + NEED_W'(HEADER_BYTES));
               state_ff <= S_F_NODE;
            end
            S_F_NODE: begin
               node_ff  <= node_of_off(off_ff, cur_b_ff);
               state_ff <= S_F_LOOP;
            end
            S_F_LOOP: begin
               if (node_ff == '0) begin
                  state_ff <= S_F_PUSH;
               end else begin
                  fnode_ff <= node_ff;
                  ret_ff   <= S_F_FLIPPED;
                  state_ff <= S_FLIP;
               end
            end
            S_F_FLIPPED: begin
               if (flip_ff || cur_b_ff == rb_ff) begin
                  state_ff <= S_F_PUSH;
               end else begin
                  // pull the buddy off its list before merging up
                  sub_b_ff <= cur_b_ff;
                  sub_s_ff <= LINK_FW'(node_slot(((node_ff - NODE_W'(1)) ^ NODE_W'(1))
                                                 + NODE_W'(1), cur_b_ff));
                  ret_ff   <= S_F_UP;
                  state_ff <= S_TK0;
               end
            end
            S_F_UP: begin
               node_ff  <= (node_ff - NODE_W'(1)) >> 1;
               cur_b_ff <= cur_b_ff - BKT_W'(1);
               state_ff <= S_F_LOOP;
            end
            S_F_PUSH: begin
               sub_b_ff <= cur_b_ff;
               sub_s_ff <= LINK_FW'(node_slot(node_ff, cur_b_ff));
               ret_ff   <= S_DONE_OK;
               state_ff <= S_PU0;
            end
            S_DONE_OK, S_DONE_FAIL: begin
               rsp_valid_ff   <= 1'b1;
               rsp_success_ff <= (state_ff == S_DONE_OK);
               rsp_addr_ff    <= '0;
               state_ff       <= S_IDLE;
            end

            // ---------------- lazy growth of the tree ----------------
            S_G_CHK: begin
               if (target_ff < rb_ff) begin
                  state_ff <= S_G_DEC;
               end else begin
                  grow_ok_ff <= 1'b1;
                  state_ff   <= gret_ff;
               end
            end
            S_G_DEC: begin
               if (sp_rdata == 1'b0) begin
                  // root block is whole: move it one level up
                  sub_b_ff <= rb_ff;
                  sub_s_ff <= '0;
                  ret_ff   <= S_G_A1;
                  state_ff <= S_TK0;
               end else begin
                  sum_ff   <= SUM_W'(hs_ff) + SUM_W'({gright, {LEAF_LOG2{1'b0}}})
                              + SUM_W'(LINK_BYTES);
                  ret_ff   <= S_G_B1;
                  state_ff <= S_MARK;
               end
            end
            S_G_A1: begin
               rb_ff                         <= rb_ff - BKT_W'(1);
               heads_ff[rb_ff - BKT_W'(1)]   <= NIL;
               sub_b_ff                      <= rb_ff - BKT_W'(1);
               sub_s_ff                      <= '0;
               ret_ff                        <= S_G_CHK;
               state_ff                      <= S_PU0;
            end
            S_G_B1: begin
               if (!mark_ok_ff) begin
                  grow_ok_ff <= 1'b0;
                  state_ff   <= gret_ff;
               end else begin
                  sub_b_ff <= rb_ff;
                  sub_s_ff <= LINK_FW'(gright);
                  ret_ff   <= S_G_B2;
                  state_ff <= S_PU0;
               end
            end
            S_G_B2: begin
               rb_ff                       <= rb_ff - BKT_W'(1);
               heads_ff[rb_ff - BKT_W'(1)] <= NIL;
               fnode_ff                    <= root_node(rb_ff - BKT_W'(1));
               ret_ff                      <= S_G_CHK;
               state_ff <= (rb_ff == BKT_W'(1)) ? S_G_CHK : S_FLIP;
            end

            // ---------------- shared steps ----------------
            S_MARK: begin
               if (SUM_W'(hw_ff) < sum_ff) begin
                  if (sum_ff > SUM_W'(lim_ff)) begin
                     mark_ok_ff <= 1'b0;
                  end else begin
                     mark_ok_ff <= 1'b1;
                     hw_ff      <= sum_ff[ADDR_W-1:0];
                  end
               end else begin
                  mark_ok_ff <= 1'b1;
               end
               state_ff <= ret_ff;
            end
            S_FLIP:  state_ff <= S_FLIP2;
            S_FLIP2: begin
               flip_ff  <= ~sp_rdata[0];
               state_ff <= ret_ff;
            end
            S_PO0: begin
               s_ff <= heads_ff[sub_b_ff];
               if (heads_ff[sub_b_ff] == NIL) begin
                  state_ff <= ret_ff;
               end else begin
                  sub_s_ff <= heads_ff[sub_b_ff];
                  state_ff <= S_TK0;
               end
            end
            S_PU0: begin
               n_ff               <= heads_ff[sub_b_ff];
               heads_ff[sub_b_ff] <= LINK_FW'(sub_s_ff[SLOT_W-1:0]);
               state_ff           <= (heads_ff[sub_b_ff] != NIL) ? S_PU1 : ret_ff;
            end
            S_PU1: state_ff <= S_PU2;
            S_PU2: state_ff <= ret_ff;
            S_TK0: state_ff <= S_TK1;
            S_TK1: begin
               p_ff <= tk_prev;
               n_ff <= lk_rdata[LINK_FW-1:0];
               if (tk_prev == NIL) begin
                  heads_ff[sub_b_ff] <= lk_rdata[LINK_FW-1:0];
                  state_ff           <= S_TK3;
               end else begin
                  state_ff <= S_TK2;
               end
            end
            S_TK2: state_ff <= S_TK3;
            S_TK3: state_ff <= (n_ff != NIL) ? S_TK4 : ret_ff;
            S_TK4: state_ff <= ret_ff;
            default: state_ff <= S_IDLE;
         endcase

         // register writes; the host issues them only between words (the block does not enforce this)
         if (cfg_wr) begin
            if (paddr[CSR_SEL] == REG_HEAP_START) begin
               hs_ff <= pwdata[ADDR_W-1:0];
               hw_ff <= base_mark[ADDR_W] ? '1 : base_mark[ADDR_W-1:0];
            end else begin
               lim_ff <= pwdata[ADDR_W-1:0];
            end
         end
      end
   end

   // ---------------- checks ----------------
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without work");

   a_root_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (rb_ff <= $past(rb_ff)))
      else $error("root bucket grew back");

   a_grant_success: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_granted_address != '0) |-> rsp_success)
      else $error("granted address on failed word");

endmodule
`default_nettype wire
